// ----- design/tib_pkg.sv -----
package tib_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 48;
	localparam int TAG_BITS    = 32;
	localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_BITS  = TIME_BITS + TAG_BITS;
	localparam int IN_BITS     = ((ENTRY_BITS + 7) / 8) * 8;
	localparam int RES_BITS    = 3 + TIME_BITS + TAG_BITS + CNT_BITS;
	localparam int OUT_BITS    = ((RES_BITS + 7) / 8) * 8;

	typedef logic [PTR_BITS-1:0]  ptr_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [TAG_BITS-1:0]  tag_t;

	// One stored event, time in the low bits
	typedef struct packed {
		tag_t  tag;
		time_t stamp;
	} entry_t;

	// Memory access request from the sequencer
	typedef struct packed {
		logic   wr_en;
		ptr_t   wr_addr;
		entry_t wr_data;
		logic   rd_en;
		ptr_t   rd_addr;
	} ram_req_t;

	// One result item, last field in the low bits
	typedef struct packed {
		cnt_t  fill_level;
		tag_t  evicted_tag;
		time_t evicted_time;
		logic  evicted_valid;
		logic  dropped;
		logic  is_newest;
	} result_t;

endpackage

// ----- design/tib_ram.sv -----
module tib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/tib_ctrl.sv -----
module tib_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tib_pkg::time_t    in_time,
	input  tib_pkg::tag_t     in_tag,
	output logic              idle,
	output tib_pkg::ram_req_t ram_req,
	input  tib_pkg::entry_t   ram_rd_data,
	input  logic              res_ready,
	output logic              res_valid,
	output tib_pkg::result_t  res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EV_RD,
		ST_EV_CHK,
		ST_SC_RD,
		ST_SC_CMP,
		ST_FIN
	} state_t;

	state_t          state_q;
	tib_pkg::ptr_t   head_q;
	tib_pkg::cnt_t   count_q;
	tib_pkg::cnt_t   k_q;
	tib_pkg::time_t  time_q;
	tib_pkg::tag_t   tag_q;
	logic            ev_valid_q;
	tib_pkg::entry_t ev_q;
	logic            drop_q;
	logic            newest_q;

	logic            later;
	logic            full;
	logic            scan_end;
	tib_pkg::ptr_t   k_ptr;
	tib_pkg::entry_t new_entry;

	// Shared compare: stored entry sorts after the incoming event
	assign later     = ram_rd_data.stamp > time_q;
	assign full      = count_q == tib_pkg::CNT_BITS'(tib_pkg::QUEUE_DEPTH);
	assign k_ptr     = k_q[tib_pkg::PTR_BITS-1:0];
	assign new_entry = '{tag: tag_q, stamp: time_q};
	assign idle      = state_q == ST_IDLE;

	// Stop the scan at the oldest kept entry; the evicted slot is not scanned
	assign scan_end  = k_q == (ev_valid_q ? count_q - tib_pkg::CNT_BITS'(1) : count_q);

	// Memory accesses: read the oldest entry when full; in the scan read one slot back, move it one slot up
	always_comb begin
		ram_req = '0;
		case (state_q)
			ST_EV_RD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = head_q;
			end
			ST_SC_RD: begin
				if (scan_end) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = head_q - k_ptr;
					ram_req.wr_data = new_entry;
				end else begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = head_q - k_ptr - tib_pkg::PTR_BITS'(1);
				end
			end
			ST_SC_CMP: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = head_q - k_ptr;
				ram_req.wr_data = later ? ram_rd_data : new_entry;
			end
			default: ram_req = '0;
		endcase
	end

	// Result of the finished step
	always_comb begin
		res_valid         = (state_q == ST_FIN) && res_ready;
		res.is_newest     = !drop_q && newest_q;
		res.dropped       = drop_q;
		res.evicted_valid = ev_valid_q;
		res.evicted_time  = ev_valid_q ? ev_q.stamp : '0;
		res.evicted_tag   = ev_valid_q ? ev_q.tag : '0;
		res.fill_level    = (drop_q || ev_valid_q) ? count_q
			: count_q + tib_pkg::CNT_BITS'(1);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			k_q        <= '0;
			ev_valid_q <= 1'b0;
			drop_q     <= 1'b0;
			newest_q   <= 1'b0;
			time_q     <= '0;
			tag_q      <= '0;
			ev_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						time_q     <= in_time;
						tag_q      <= in_tag;
						k_q        <= '0;
						ev_valid_q <= 1'b0;
						drop_q     <= 1'b0;
						state_q    <= full ? ST_EV_RD : ST_SC_RD;
					end
				end
				ST_EV_RD: state_q <= ST_EV_CHK;
				ST_EV_CHK: begin
					// oldest entry is later than the event: drop the event
					if (later) begin
						drop_q  <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						ev_valid_q <= 1'b1;
						ev_q       <= ram_rd_data;
						state_q    <= ST_SC_RD;
					end
				end
				ST_SC_RD: begin
					if (scan_end) begin
						newest_q <= k_q == '0;
						state_q  <= ST_FIN;
					end else begin
						state_q <= ST_SC_CMP;
					end
				end
				ST_SC_CMP: begin
					if (later) begin
						k_q     <= k_q + tib_pkg::CNT_BITS'(1);
						state_q <= ST_SC_RD;
					end else begin
						newest_q <= k_q == '0;
						state_q  <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (res_ready) begin
						if (!drop_q) begin
							head_q <= head_q + tib_pkg::PTR_BITS'(1);
							if (!ev_valid_q) begin
								count_q <= count_q + tib_pkg::CNT_BITS'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/time_ordered_insert_buffer_top.sv -----
// Time-ordered insert buffer: keeps up to 16 events sorted by sample time in a
// single-port-write, registered-read ring memory. Each event is taken as one
// transfer and gives exactly one result transfer. A small sequencer walks the
// ring from the newest entry backward with one shared comparator, moving each
// later entry up by one slot (read, then compare and write in the next cycle),
// and writes the event into the freed slot. When the buffer is full it first
// reads and checks the oldest entry, and an event earlier than it is dropped
// without a scan. A finished result waits while the output register is still
// full. s_tready is low while an event is in work; a result waiting in the
// output register does not stop the next input transfer.
module time_ordered_insert_buffer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// sample_time, payload_tag
	input  logic [tib_pkg::IN_BITS-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// is_newest, dropped, evicted_valid, evicted_time, evicted_tag, fill_level
	output logic [tib_pkg::OUT_BITS-1:0] m_tdata
);

	tib_pkg::ram_req_t ram_req;
	tib_pkg::entry_t   ram_rd_data;
	tib_pkg::result_t  res;
	tib_pkg::result_t  res_q;
	logic              res_valid;
	logic              res_ready;
	logic              idle;
	logic              out_valid_q;

	assign s_tready  = idle;
	assign res_ready = !out_valid_q || m_tready;

	tib_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (s_tvalid && idle),
		.in_time     (s_tdata[tib_pkg::TIME_BITS-1:0]),
		.in_tag      (s_tdata[tib_pkg::ENTRY_BITS-1:tib_pkg::TIME_BITS]),
		.idle        (idle),
		.ram_req     (ram_req),
		.ram_rd_data (ram_rd_data),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res)
	);

	tib_ram #(
		.WIDTH (tib_pkg::ENTRY_BITS),
		.DEPTH (tib_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (ram_rd_data)
	);

	// Output register: load a finished result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid) begin
				out_valid_q <= 1'b1;
				res_q       <= res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tib_pkg::OUT_BITS'(res_q);

	// A transfer in starts a step that blocks further input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a step is in work");

	// A dropped event reports a full buffer and nothing else
	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.dropped |-> !res_q.is_newest && !res_q.evicted_valid
			&& res_q.fill_level == tib_pkg::CNT_BITS'(tib_pkg::QUEUE_DEPTH))
		else $error("dropped result malformed");

	// Eviction only happens with a full buffer
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.evicted_valid
			|-> res_q.fill_level == tib_pkg::CNT_BITS'(tib_pkg::QUEUE_DEPTH))
		else $error("eviction below full");

	// Fill level never passes the depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_q.fill_level <= tib_pkg::CNT_BITS'(tib_pkg::QUEUE_DEPTH))
		else $error("fill level out of range");

endmodule

// ----- tb/sv/tb_time_ordered_insert_buffer_top.sv -----
`timescale 1ns / 100ps

module tb_time_ordered_insert_buffer_top;

	import tib_pkg::*;

	localparam int    RUN_LIMIT    = 600000;
	localparam int    DRAIN_CYCLES = 40;
	localparam int    HOLD_CYCLES  = 400;
	localparam int    RANDOM_ITEMS = 1200;
	localparam time_t STAMP_MAX    = {TIME_BITS{1'b1}};
	localparam time_t STAMP_CEIL   = STAMP_MAX - 48'h100_0000;
	localparam tag_t  TAG_MAX      = {TAG_BITS{1'b1}};

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_EVERY_4TH,
		READY_MOSTLY
	} ready_mode_e;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// sample_time, payload_tag
	logic [IN_BITS-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// is_newest, dropped, evicted_valid, evicted_time, evicted_tag, fill_level
	logic [OUT_BITS-1:0] m_tdata;

	// Sorted copy of the stored events, oldest first
	entry_t  held_events[$];
	result_t pending_results[$];

	time_t       now_stamp = '0;
	int          burst_left = 0;
	bit          long_hold_req = 1'b0;
	int          hold_left = 0;
	int          mode_left = 0;
	int unsigned ready_phase = 0;
	ready_mode_e ready_mode = READY_ALWAYS;
	int          cycle_count = 0;
	int          n_sent = 0;
	int          n_results = 0;
	int          n_newest = 0;
	int          n_evicted = 0;
	int          n_dropped = 0;
	int          n_errors = 0;
	result_t     got_result;
	result_t     want_result;

	time_ordered_insert_buffer_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("Timeout after %0d cycles", RUN_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Insert one event into the sorted copy and return the result it causes
	function automatic result_t sorted_insert(entry_t ev);
		result_t r;
		int      pos;
		r = '0;
		pos = 0;
		while (pos < held_events.size() && held_events[pos].stamp <= ev.stamp)
			pos++;
		r.is_newest = (pos == held_events.size());
		if (held_events.size() == QUEUE_DEPTH) begin
			// full and older than everything held: drop, keep the store
			if (pos == 0) begin
				r.is_newest  = 1'b0;
				r.dropped    = 1'b1;
				r.fill_level = cnt_t'(QUEUE_DEPTH);
				return r;
			end
			// push the oldest out to make room
			r.evicted_valid = 1'b1;
			r.evicted_time  = held_events[0].stamp;
			r.evicted_tag   = held_events[0].tag;
			void'(held_events.pop_front());
			pos--;
		end
		held_events.insert(pos, ev);
		r.fill_level = cnt_t'(held_events.size());
		return r;
	endfunction

	// Offer one event in bursts with random gaps, then record its result
	task automatic send_event(time_t stamp, tag_t tag);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= entry_t'{tag: tag, stamp: stamp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(sorted_insert(entry_t'{tag: tag, stamp: stamp}));
		burst_left--;
		n_sent++;
	endtask

	// Pick a time stamp: mostly rising arrivals, some late, equal or far off
	function automatic time_t pick_stamp();
		int unsigned pick;
		int unsigned back;
		time_t       probe;
		pick = $urandom_range(0, 99);
		if (now_stamp < STAMP_CEIL)
			now_stamp = now_stamp + time_t'($urandom_range(0, 1500));
		if (pick < 60)
			return now_stamp;
		if (pick < 80) begin
			back = $urandom_range(1, 24000);
			return (now_stamp > back) ? now_stamp - time_t'(back) : '0;
		end
		if (pick < 88 && held_events.size() != 0)
			return held_events[$urandom_range(0, held_events.size() - 1)].stamp;
		if (pick < 97) begin
			probe = time_t'({$urandom, $urandom});
			if (probe > now_stamp && probe < STAMP_CEIL)
				now_stamp = probe;
			return probe;
		end
		return '0;
	endfunction

	// Receiver: long hold on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (long_hold_req) begin
			hold_left = HOLD_CYCLES;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = ready_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(64, 256);
			end
			mode_left--;
			ready_phase++;
			case (ready_mode)
				READY_ALWAYS:    m_tready <= 1'b1;
				READY_COIN:      m_tready <= 1'($urandom_range(0, 1));
				READY_EVERY_4TH: m_tready <= (ready_phase % 4 == 0);
				default:         m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = result_t'(m_tdata);
			n_results++;
			if (pending_results.size() == 0) begin
				$error("Result with no event outstanding: %h", m_tdata);
				n_errors++;
			end else begin
				want_result = pending_results.pop_front();
				if (got_result.is_newest !== want_result.is_newest) begin
					$error("is_newest: expected %0d, got %0d",
						want_result.is_newest, got_result.is_newest);
					n_errors++;
				end
				if (got_result.dropped !== want_result.dropped) begin
					$error("dropped: expected %0d, got %0d",
						want_result.dropped, got_result.dropped);
					n_errors++;
				end
				if (got_result.evicted_valid !== want_result.evicted_valid) begin
					$error("evicted_valid: expected %0d, got %0d",
						want_result.evicted_valid, got_result.evicted_valid);
					n_errors++;
				end
				if (got_result.evicted_time !== want_result.evicted_time) begin
					$error("evicted_time: expected %h, got %h",
						want_result.evicted_time, got_result.evicted_time);
					n_errors++;
				end
				if (got_result.evicted_tag !== want_result.evicted_tag) begin
					$error("evicted_tag: expected %h, got %h",
						want_result.evicted_tag, got_result.evicted_tag);
					n_errors++;
				end
				if (got_result.fill_level !== want_result.fill_level) begin
					$error("fill_level: expected %0d, got %0d",
						want_result.fill_level, got_result.fill_level);
					n_errors++;
				end
				n_newest  += want_result.is_newest;
				n_evicted += want_result.evicted_valid;
				n_dropped += want_result.dropped;
			end
		end
	end

	// Fill from empty: zero stamps and tags, equal stamps, inserts in the middle
	task automatic test_partial_fill();
		send_event('0, '0);
		send_event('0, TAG_MAX);
		send_event(48'd5000, 32'h0000_0005);
		send_event(48'd3000, 32'h0000_0003);
		send_event(48'd7000, 32'h0000_0007);
		send_event(48'd3000, 32'h0000_0033);
		send_event(48'd1000, 32'h0000_0001);
		send_event(48'd9000, 32'h0000_0009);
		send_event(48'd2000, 32'h0000_0002);
		send_event(48'd6000, 32'h0000_0006);
		send_event(48'd4000, 32'h0000_0004);
		send_event(48'd8000, 32'h0000_0008);
		send_event(48'd2500, 32'h0000_0025);
		send_event(48'd7500, 32'h0000_0075);
	endtask

	// Reach full, then evict as newest, evict on a middle insert, and drop
	task automatic test_full_buffer();
		send_event(48'd9500, 32'h0000_0095);
		send_event(48'd1500, 32'h0000_0015);
		send_event(48'd20000, 32'hAAAA_AAAA);
		send_event('0, 32'h5555_5555);
		send_event(48'd4500, 32'h0000_0045);
		send_event(48'd999, 32'hDEAD_0001);
		send_event(48'd1000, 32'h0000_1000);
		send_event('0, 32'hDEAD_0002);
		now_stamp = 48'd20000;
	endtask

	// Mostly rising stamps with random tags, some late, equal and wild ones
	task automatic test_random_events();
		repeat (RANDOM_ITEMS) send_event(pick_stamp(), tag_t'($urandom));
	endtask

	// Hold the receiver off while events keep coming so the input stalls
	task automatic test_output_backpressure();
		long_hold_req = 1'b1;
		burst_left = 32;
		repeat (32) send_event(pick_stamp(), tag_t'($urandom));
	endtask

	// Largest stamp and tag last, since such entries never age out
	task automatic test_stamp_extremes();
		send_event(STAMP_MAX, TAG_MAX);
		send_event(STAMP_MAX, '0);
		send_event(STAMP_MAX - 48'd1, 32'h8000_0001);
		send_event('0, TAG_MAX);
	endtask

	// Let every result come back, then some slack for stray output
	task automatic drain_results();
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_partial_fill();
		test_full_buffer();
		test_random_events();
		test_output_backpressure();
		test_stamp_extremes();
		drain_results();
		$display("Sent %0d events and checked %0d results in %0d cycles",
			n_sent, n_results, cycle_count);
		$display("Results: %0d placed newest, %0d with eviction, %0d dropped",
			n_newest, n_evicted, n_dropped);
		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
